// ----- rtl/wpm_pkg.sv -----
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int CHAR_W          = 8;
	localparam int IN_TDATA_W      = 8;
	localparam int IN_TUSER_W      = 3;
	localparam int OUT_TDATA_W     = 8;
	localparam int REG_IDX_W       = 1;
	localparam int REG_DATA_W      = 8;

	localparam logic [CHAR_W-1:0] SINGLE_RST = 8'd63;
	localparam logic [CHAR_W-1:0] MULTI_RST  = 8'd42;
	localparam logic [CHAR_W-1:0] QUOTE_DBL  = 8'h22;
	localparam logic [CHAR_W-1:0] QUOTE_SGL  = 8'h27;

	localparam logic [REG_IDX_W-1:0] REG_SINGLE = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MULTI  = 1'd1;

	typedef enum logic [1:0] {
		CMD_PATTERN = 2'd0,
		CMD_SUBJECT = 2'd1,
		CMD_END     = 2'd2
	} cmd_t;

	// broadcast to every cell
	typedef struct packed {
		logic              load;
		logic              first;
		logic              step;
		logic              restart;
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] single_wc;
		logic [CHAR_W-1:0] multi_wc;
	} ctrl_t;

	// neighbour link, cell p-1 to cell p
	typedef struct packed {
		logic used;
		logic cc;
		logic adv;
	} link_t;

endpackage

// ----- rtl/wpm_cell.sv -----
// One pattern position: stored character, in-use bit and active bit.
module wpm_cell #(
	parameter bit FIRST_CELL = 1'b0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wpm_pkg::ctrl_t               ctrl,
	input  wpm_pkg::link_t               link_in,
	output wpm_pkg::link_t               link_out,
	output logic                         hit,
	output logic [wpm_pkg::CHAR_W-1:0]   ch_o
);
	import wpm_pkg::*;

	logic [CHAR_W-1:0] ch_q;
	logic              used_q;
	logic              act_q;
	logic              write_here;
	logic              is_single;
	logic              is_star;
	logic              closed;

	assign is_single  = (ch_q == ctrl.single_wc);
	assign is_star    = ~is_single & (ch_q == ctrl.multi_wc);
	assign closed     = act_q | link_in.cc;
	assign write_here = ctrl.load & (ctrl.first ? FIRST_CELL : (link_in.used & ~used_q));

	assign link_out.used = used_q;
	assign link_out.cc   = closed & used_q & is_star;
	assign link_out.adv  = closed & used_q & ~is_star & (is_single | (ch_q == ctrl.ch));
	assign hit           = closed & link_in.used & ~used_q;
	assign ch_o          = ch_q;

	always_ff @(posedge clk) begin
		if (write_here) begin
			ch_q <= ctrl.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= FIRST_CELL;
		end else begin
			if (ctrl.load && ctrl.first) begin
				used_q <= FIRST_CELL;
			end else if (write_here) begin
				used_q <= 1'b1;
			end
			if (ctrl.restart) begin
				act_q <= FIRST_CELL;
			end else if (ctrl.step) begin
				act_q <= link_out.cc | link_in.adv;
			end
		end
	end

endmodule

// ----- rtl/wildcard_pattern_matcher_core.sv -----
// Top level of the wildcard pattern matcher: cell chain, terminal position and result register.
// Throughput: one pattern, subject or end transfer per cycle while no result waits unread.
// The result shows on the output register in the cycle after the end-of-subject transfer.
// A subject character's position-set update ripples once through the row of cells.
// Input is taken whenever the output register is empty or being drained.
// Reset: pattern empty, overflow clear, position zero active, wildcard codes '?' and '*'.
module wildcard_pattern_matcher_core #(
	parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wpm_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] ch
	input  logic [wpm_pkg::IN_TUSER_W-1:0]    s_tuser,  // [1:0] cmd, [2] first
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wpm_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [0] matched, [1] pattern_overflow
	input  logic                              wr_en,
	input  logic [wpm_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [wpm_pkg::REG_DATA_W-1:0]    wr_data
);
	import wpm_pkg::*;

	logic [CHAR_W-1:0] single_q;
	logic [CHAR_W-1:0] multi_q;
	logic              ovf_q;
	logic              term_q;
	logic              m_valid_q;
	logic              matched_q;
	logic              ovf_out_q;
	logic              accept;
	cmd_t              cmd;
	ctrl_t             ctrl;
	link_t             link [PATTERN_MAX+1];
	logic [CHAR_W-1:0] cell_ch [PATTERN_MAX];
	logic [PATTERN_MAX:0] hit_v;
	logic              term_closed;
	logic              all_one;
	logic              all_three;
	logic              matched;

	assign cmd      = cmd_t'(s_tuser[1:0]);
	assign s_tready = ~m_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		ctrl           = '0;
		ctrl.ch        = s_tdata[CHAR_W-1:0];
		ctrl.first     = s_tuser[2];
		ctrl.single_wc = single_q;
		ctrl.multi_wc  = multi_q;
		case (cmd)
			CMD_PATTERN: begin
				ctrl.load    = accept;
				ctrl.restart = accept;
			end
			CMD_SUBJECT: ctrl.step    = accept;
			CMD_END:     ctrl.restart = accept;
			default:     ctrl.step    = 1'b0;
		endcase
	end

	assign link[0] = '{used: 1'b1, cc: 1'b0, adv: 1'b0};

	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			wpm_cell #(
				.FIRST_CELL(gi == 0)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.link_in  (link[gi]),
				.link_out (link[gi+1]),
				.hit      (hit_v[gi]),
				.ch_o     (cell_ch[gi])
			);
		end
	endgenerate

	assign term_closed        = term_q | link[PATTERN_MAX].cc;
	assign hit_v[PATTERN_MAX] = term_closed & link[PATTERN_MAX].used;

	assign all_one = link[1].used & ~link[2].used & (cell_ch[0] == multi_q);

	generate
		if (PATTERN_MAX >= 4) begin : g_three
			assign all_three = link[3].used & ~link[4].used & (cell_ch[1] == multi_q) &
				(cell_ch[0] == cell_ch[2]) &
				((cell_ch[0] == QUOTE_DBL) | (cell_ch[0] == QUOTE_SGL));
		end else if (PATTERN_MAX == 3) begin : g_three_full
			assign all_three = link[3].used & (cell_ch[1] == multi_q) &
				(cell_ch[0] == cell_ch[2]) &
				((cell_ch[0] == QUOTE_DBL) | (cell_ch[0] == QUOTE_SGL));
		end else begin : g_no_three
			assign all_three = 1'b0;
		end
	endgenerate

	assign matched = all_one | all_three | (|hit_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= SINGLE_RST;
			multi_q  <= MULTI_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SINGLE: single_q <= wr_data[CHAR_W-1:0];
				REG_MULTI:  multi_q  <= wr_data[CHAR_W-1:0];
				default:    single_q <= single_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q     <= 1'b0;
			term_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				ovf_q <= ~ctrl.first & (ovf_q | link[PATTERN_MAX].used);
			end
			if (ctrl.restart) begin
				term_q <= 1'b0;
			end else if (ctrl.step) begin
				term_q <= link[PATTERN_MAX].adv;
			end
			if (accept && cmd == CMD_END) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_END) begin
			matched_q <= matched;
			ovf_out_q <= ovf_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, ovf_out_q, matched_q};

	a_term_in_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		term_q |-> link[PATTERN_MAX].used)
		else $error("terminal position active without a full pattern");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> link[PATTERN_MAX].used)
		else $error("overflow flagged with free pattern cells");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_END) |=> m_tvalid)
		else $error("end-of-subject transfer gave no result");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_PATTERN) |=> !term_q)
		else $error("terminal position survived a pattern load");

endmodule
